@@ rtl/great_circle_distance_macros.svh @@
// Assertion macros for the great-circle distance RTL.
`ifndef GREAT_CIRCLE_DISTANCE_MACROS_SVH
`define GREAT_CIRCLE_DISTANCE_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define GCD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("great_circle_distance: check failed");

// Antecedent implies consequent in the next cycle.
`define GCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("great_circle_distance: check failed");

`endif

@@ rtl/gcd_pkg.sv @@
`timescale 1ns / 1ps
package gcd_pkg;

	// Q30 working word: one sign bit, two integer bits of headroom, thirty fraction bits.
	typedef logic signed [32:0] cq_t;

	localparam logic signed [30:0] HALF_TURN = 31'sd188743680;
	localparam logic signed [30:0] FULL_TURN = 31'sd377487360;
	localparam logic signed [30:0] QUARTER_TURN = 31'sd94371840;

	// round(pi/180 * 2^42) split into a 5-bit upper part and a 32-bit lower part.
	localparam logic [4:0] DEG2RAD_HI = 5'd17;
	localparam logic [31:0] DEG2RAD_LO = 32'd3745948243;

	localparam cq_t CORDIC_GAIN = 33'sd652032874;
	localparam logic signed [33:0] PI_Q30 = 34'sd3373259426;
	localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;
	localparam logic [60:0] ONE_SQ = 61'd1 << 60;

	localparam int unsigned ROOT_BITS = 31;
	localparam logic [58:0] KM_HALF = 59'd2097152000;
	// ceil(2^38 / 125) in 16-bit halves: n / 125 is (n * this) >> 38 for any n below 2^31.
	localparam logic [15:0] KM_RECIP_HI = 16'h8312;
	localparam logic [15:0] KM_RECIP_LO = 16'h6E98;
	localparam logic [36:0] SAT_LIMIT = 37'd16777216000;
	localparam logic [23:0] OUT_MAX = 24'hFFFFFF;
	localparam logic [25:0] RADIUS_RESET = 26'd6378137;

	function automatic cq_t atan_q30(input logic [4:0] k);
		cq_t r;
		unique case (k)
			5'd0: r = 33'sh03243F6A8;
			5'd1: r = 33'sh01DAC6705;
			5'd2: r = 33'sh00FADBAFC;
			5'd3: r = 33'sh007F56EA6;
			5'd4: r = 33'sh003FEAB76;
			5'd5: r = 33'sh001FFD55B;
			5'd6: r = 33'sh000FFFAAA;
			5'd7: r = 33'sh0007FFF55;
			5'd8: r = 33'sh0003FFFEA;
			5'd9: r = 33'sh0001FFFFD;
			5'd10: r = 33'sh0000FFFFF;
			5'd11: r = 33'sh00007FFFF;
			5'd12: r = 33'sh00003FFFF;
			5'd13: r = 33'sh00001FFFF;
			5'd14: r = 33'sh00000FFFF;
			5'd15: r = 33'sh000007FFF;
			5'd16: r = 33'sh000003FFF;
			5'd17: r = 33'sh000001FFF;
			5'd18: r = 33'sh000000FFF;
			5'd19: r = 33'sh0000007FF;
			5'd20: r = 33'sh0000003FF;
			5'd21: r = 33'sh0000001FF;
			5'd22: r = 33'sh0000000FF;
			5'd23: r = 33'sh00000007F;
			5'd24: r = 33'sh00000003F;
			5'd25: r = 33'sh00000001F;
			5'd26: r = 33'sh00000000F;
			5'd27: r = 33'sh000000008;
			5'd28: r = 33'sh000000004;
			5'd29: r = 33'sh000000002;
			5'd30: r = 33'sh000000001;
			5'd31: r = 33'sh000000000;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/great_circle_distance.sv @@
`timescale 1ns / 1ps
// Great-circle distance by the spherical law of cosines. A point pair is taken at every
// clock edge where start is high and busy is low; busy is high only during reset and up
// to the first clock edge after it, so a new pair may be issued every cycle. The distance
// appears on distance_km, in 1/256 km and saturated, for exactly one cycle with done
// high. The receiver cannot hold results off: every beat must be captured in the cycle
// done is high. The datapath is fully pipelined: the sine/cosine rotation CORDIC and
// the arccosine vectoring CORDIC each spend one stage per step, the square root spends
// one stage per result bit, and the final division by 1000 is a right shift for the
// factor of eight and a reciprocal multiplication for 125 over two stages. The sphere
// radius in metres is written on the cfg channel and should only change while no pair
// is in flight.
`include "great_circle_distance_macros.svh"
module great_circle_distance import gcd_pkg::*; #(
	parameter int CORDIC_STEPS = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [27:0] first_latitude,
	input  logic signed [28:0] first_longitude,
	input  logic signed [27:0] second_latitude,
	input  logic signed [28:0] second_longitude,
	output logic               done,
	output logic [23:0]        distance_km,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [25:0]        cfg_data
);

	// Stage positions in the valid chain, counted in edges after the input beat.
	localparam int SC_LAT = CORDIC_STEPS + 3;
	localparam int P3_IDX = SC_LAT + 3;
	localparam int P4_IDX = P3_IDX + 1;
	localparam int LAT = 2 * CORDIC_STEPS + 45;

	logic        busy_q;
	logic [25:0] radius_q;
	logic        accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			radius_q <= RADIUS_RESET;
		end else begin
			busy_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				radius_q <= cfg_data;
			end
		end
	end

	assign busy = busy_q;
	assign cfg_ready = !busy_q;
	assign accept = start && !busy_q;

	// The valid bit of every stage; the data registers themselves carry no reset.
	logic [LAT-1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], accept};
		end
	end

	// Input beat register. The longitude difference is formed here, so only three angles
	// need a sine and a cosine.
	logic signed [29:0] lat1_s0;
	logic signed [29:0] lat2_s0;
	logic signed [29:0] dlon_s0;

	always_ff @(posedge clk) begin
		lat1_s0 <= 30'(first_latitude);
		lat2_s0 <= 30'(second_latitude);
		dlon_s0 <= 30'(second_longitude) - 30'(first_longitude);
	end

	cq_t sin1, cos1, sin2, cos2, sind, cosd;

	gcd_sincos #(.CORDIC_STEPS(CORDIC_STEPS)) u_sc_lat1 (
		.clk(clk), .angle(lat1_s0), .sine(sin1), .cosine(cos1)
	);
	gcd_sincos #(.CORDIC_STEPS(CORDIC_STEPS)) u_sc_lat2 (
		.clk(clk), .angle(lat2_s0), .sine(sin2), .cosine(cos2)
	);
	gcd_sincos #(.CORDIC_STEPS(CORDIC_STEPS)) u_sc_dlon (
		.clk(clk), .angle(dlon_s0), .sine(sind), .cosine(cosd)
	);

	// The sine of the longitude difference is not needed by the law of cosines.
	logic sind_unused;
	assign sind_unused = ^sind;

	// Products of Q30 values, each floored back to Q30.
	logic signed [65:0] prod_ss;
	logic signed [65:0] prod_cc;
	cq_t m1_s1, m2_s1, cd_s1;

	assign prod_ss = 66'(sin1) * 66'(sin2);
	assign prod_cc = 66'(cos1) * 66'(cos2);

	always_ff @(posedge clk) begin
		m1_s1 <= prod_ss[62:30];
		m2_s1 <= prod_cc[62:30];
		cd_s1 <= cosd;
	end

	logic signed [65:0] prod_cd;
	cq_t m1_s2, m3_s2;

	assign prod_cd = 66'(m2_s1) * 66'(cd_s1);

	always_ff @(posedge clk) begin
		m1_s2 <= m1_s1;
		m3_s2 <= prod_cd[62:30];
	end

	// The cosine of the central angle, clamped to [-1,1] against rounding.
	logic signed [33:0] s_sum;
	logic signed [31:0] s_s3;

	assign s_sum = 34'(m1_s2) + 34'(m3_s2);

	always_ff @(posedge clk) begin
		if (s_sum > ONE_Q30) begin
			s_s3 <= 32'(ONE_Q30);
		end else if (s_sum < -ONE_Q30) begin
			s_s3 <= 32'(-ONE_Q30);
		end else begin
			s_s3 <= 32'(s_sum);
		end
	end

	logic signed [63:0] s_sq;
	logic [60:0]        sq_s4;
	logic [30:0]        sabs_s [0:ROOT_BITS];
	logic               sneg_s [0:ROOT_BITS];

	assign s_sq = 64'(s_s3) * 64'(s_s3);

	always_ff @(posedge clk) begin
		sq_s4 <= s_sq[60:0];
		sabs_s[0] <= s_s3[31] ? 31'(-s_s3) : 31'(s_s3);
		sneg_s[0] <= s_s3[31];
	end

	// The sine of the central angle, sqrt(1 - s^2), while |s| and its sign ride alongside.
	logic [30:0] root;

	gcd_isqrt u_isqrt (
		.clk(clk), .radicand(ONE_SQ - sq_s4), .root(root)
	);

	for (genvar j = 0; j < ROOT_BITS; j++) begin : g_spipe
		always_ff @(posedge clk) begin
			sabs_s[j+1] <= sabs_s[j];
			sneg_s[j+1] <= sneg_s[j];
		end
	end

	// Vectoring CORDIC: atan2(sqrt(1-s^2), |s|) accumulates in az_s.
	cq_t ax_s [0:CORDIC_STEPS-1];
	cq_t ay_s [0:CORDIC_STEPS-1];
	cq_t az_s [0:CORDIC_STEPS];
	logic aneg_s [0:CORDIC_STEPS];

	always_ff @(posedge clk) begin
		ax_s[0] <= $signed({2'b00, sabs_s[ROOT_BITS]});
		ay_s[0] <= $signed({2'b00, root});
		az_s[0] <= '0;
		aneg_s[0] <= sneg_s[ROOT_BITS];
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_acos
		localparam cq_t ATAN = atan_q30(5'(i));
		logic up;
		assign up = !ay_s[i][32] && (ay_s[i] != '0);
		always_ff @(posedge clk) begin
			az_s[i+1] <= up ? az_s[i] + ATAN : az_s[i] - ATAN;
			aneg_s[i+1] <= aneg_s[i];
		end
		if (i < CORDIC_STEPS - 1) begin : g_xy
			always_ff @(posedge clk) begin
				if (up) begin
					ax_s[i+1] <= ax_s[i] + (ay_s[i] >>> i);
					ay_s[i+1] <= ay_s[i] - (ax_s[i] >>> i);
				end else begin
					ax_s[i+1] <= ax_s[i] - (ay_s[i] >>> i);
					ay_s[i+1] <= ay_s[i] + (ax_s[i] >>> i);
				end
			end
		end
	end

	// Mirror to pi minus the angle for a negative cosine; a slightly negative angle is zero.
	logic signed [33:0] ang_c;
	logic [31:0]        ang_f1;

	assign ang_c = aneg_s[CORDIC_STEPS] ? PI_Q30 - 34'(az_s[CORDIC_STEPS])
		: 34'(az_s[CORDIC_STEPS]);

	always_ff @(posedge clk) begin
		ang_f1 <= ang_c[33] ? '0 : ang_c[31:0];
	end

	// Radius times angle, split over two 26x16 partial products.
	logic [41:0] plo_f2;
	logic [41:0] phi_f2;

	always_ff @(posedge clk) begin
		plo_f2 <= 42'(radius_q) * 42'(ang_f1[15:0]);
		phi_f2 <= 42'(radius_q) * 42'(ang_f1[31:16]);
	end

	// Round, drop the 2^22 factor together with the factor of eight in 1000, and flag
	// results that cannot fit the output field. Below that limit the value fits 31 bits.
	logic [58:0] km_sum;
	logic [30:0] q_f3;
	logic        sat_f3;

	assign km_sum = {1'b0, phi_f2, 16'd0} + 59'(plo_f2) + KM_HALF;

	always_ff @(posedge clk) begin
		q_f3 <= km_sum[55:25];
		sat_f3 <= km_sum[58:22] >= SAT_LIMIT;
	end

	// The remaining division by 125 is a multiplication by its reciprocal, split over
	// two 31x16 partial products; the sum and the saturation fill the next stage.
	logic [46:0] mlo_f4;
	logic [46:0] mhi_f4;
	logic        sat_f4;

	always_ff @(posedge clk) begin
		mlo_f4 <= 47'(q_f3) * 47'(KM_RECIP_LO);
		mhi_f4 <= 47'(q_f3) * 47'(KM_RECIP_HI);
		sat_f4 <= sat_f3;
	end

	logic [63:0] recip_sum;

	assign recip_sum = {1'b0, mhi_f4, 16'd0} + 64'(mlo_f4);

	always_ff @(posedge clk) begin
		distance_km <= sat_f4 ? OUT_MAX : recip_sum[61:38];
	end

	assign done = vld_q[LAT-1];

	`GCD_ASSERT_IMPL(a_done_latency, clk, arst_n, done, $past(start && !busy, LAT))
	`GCD_ASSERT_IMPL(a_cos_clamped, clk, arst_n, vld_q[P3_IDX],
		(34'(s_s3) <= ONE_Q30) && (34'(s_s3) >= -ONE_Q30))
	`GCD_ASSERT_NEXT(a_unit_square, clk, arst_n, vld_q[P3_IDX] && (34'(s_s3) == ONE_Q30),
		vld_q[P4_IDX] && (sq_s4 == ONE_SQ))

endmodule

@@ rtl/gcd_sincos.sv @@
`timescale 1ns / 1ps
// Sine and cosine of an angle in degrees times 2^20.
module gcd_sincos import gcd_pkg::*; #(
	parameter int CORDIC_STEPS = 24
) (
	input  logic               clk,
	input  logic signed [29:0] angle,
	output cq_t                sine,
	output cq_t                cosine
);

	logic signed [30:0] a_wrap;
	logic signed [30:0] a_fold;
	logic               negc_c;
	logic               neg_c;
	logic [26:0]        mag_c;

	// Wrap into [-180,180), then fold into [-90,90] and remember the cosine sign.
	always_comb begin
		a_wrap = 31'(angle) + HALF_TURN;
		if (a_wrap < 0) begin
			a_wrap = a_wrap + FULL_TURN;
		end else if (a_wrap >= FULL_TURN) begin
			a_wrap = a_wrap - FULL_TURN;
		end
		a_wrap = a_wrap - HALF_TURN;
		a_fold = a_wrap;
		negc_c = 1'b0;
		if (a_wrap > QUARTER_TURN) begin
			a_fold = HALF_TURN - a_wrap;
			negc_c = 1'b1;
		end else if (a_wrap < -QUARTER_TURN) begin
			a_fold = -HALF_TURN - a_wrap;
			negc_c = 1'b1;
		end
		neg_c = a_fold[30];
		mag_c = neg_c ? 27'(-a_fold) : 27'(a_fold);
	end

	logic [26:0] mag_s1;
	logic        neg_s1;
	logic        negc_s1;

	always_ff @(posedge clk) begin
		mag_s1 <= mag_c;
		neg_s1 <= neg_c;
		negc_s1 <= negc_c;
	end

	logic [58:0] plo_s2;
	logic [31:0] phi_s2;
	logic        neg_s2;
	logic        negc_s2;

	always_ff @(posedge clk) begin
		plo_s2 <= 59'(mag_s1) * 59'(DEG2RAD_LO);
		phi_s2 <= 32'(mag_s1) * 32'(DEG2RAD_HI);
		neg_s2 <= neg_s1;
		negc_s2 <= negc_s1;
	end

	logic [63:0] rad_sum;
	logic [31:0] rad_mag;

	assign rad_sum = {phi_s2, 32'd0} + 64'(plo_s2) + (64'd1 << 31);
	assign rad_mag = rad_sum[63:32];

	cq_t z_s [0:CORDIC_STEPS-1];
	cq_t x_s [0:CORDIC_STEPS];
	cq_t y_s [0:CORDIC_STEPS];
	logic negc_s [0:CORDIC_STEPS];

	always_ff @(posedge clk) begin
		z_s[0] <= neg_s2 ? -$signed({1'b0, rad_mag}) : $signed({1'b0, rad_mag});
		x_s[0] <= CORDIC_GAIN;
		y_s[0] <= '0;
		negc_s[0] <= negc_s2;
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		localparam cq_t ATAN = atan_q30(5'(i));
		always_ff @(posedge clk) begin
			if (!z_s[i][32]) begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
			end else begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
			end
			negc_s[i+1] <= negc_s[i];
		end
		if (i < CORDIC_STEPS - 1) begin : g_z
			always_ff @(posedge clk) begin
				z_s[i+1] <= z_s[i][32] ? z_s[i] + ATAN : z_s[i] - ATAN;
			end
		end
	end

	assign sine = y_s[CORDIC_STEPS];
	assign cosine = negc_s[CORDIC_STEPS] ? -x_s[CORDIC_STEPS] : x_s[CORDIC_STEPS];

endmodule

@@ rtl/gcd_isqrt.sv @@
`timescale 1ns / 1ps
// Floor square root of a 61-bit value, one result bit per stage, ROOT_BITS stages.
module gcd_isqrt import gcd_pkg::*; (
	input  logic        clk,
	input  logic [60:0] radicand,
	output logic [30:0] root
);

	logic [61:0] v_s [1:ROOT_BITS-1];
	logic [61:0] r_s [1:ROOT_BITS];

	for (genvar j = 0; j < ROOT_BITS; j++) begin : g_bit
		localparam logic [61:0] BIT = 62'd1 << (2 * (ROOT_BITS - 1 - j));
		logic [61:0] v_in;
		logic [61:0] r_in;
		logic        take;

		if (j == 0) begin : g_first
			assign v_in = {1'b0, radicand};
			assign r_in = '0;
		end else begin : g_next
			assign v_in = v_s[j];
			assign r_in = r_s[j];
		end

		assign take = v_in >= r_in + BIT;

		always_ff @(posedge clk) begin
			r_s[j+1] <= take ? (r_in >> 1) + BIT : r_in >> 1;
		end
		if (j < ROOT_BITS - 1) begin : g_rem
			always_ff @(posedge clk) begin
				v_s[j+1] <= take ? v_in - (r_in + BIT) : v_in;
			end
		end
	end

	assign root = r_s[ROOT_BITS][30:0];

endmodule
